FILE: rtl/wfst_pkg.sv
// ----------------------------------------------------------------------------
// wfst_pkg: shared types and constants for the WPAN frame source tracker
// Function codes, result status codes and controller command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wfst_pkg;

  localparam int unsigned DefTableDepth = 32;
  localparam int unsigned HdrDepth      = 24;

  localparam logic [1:0] FuncByte  = 2'd0;
  localparam logic [1:0] FuncRead  = 2'd1;
  localparam logic [1:0] FuncClear = 2'd2;
  localparam logic [1:0] FuncNone  = 2'd3;

  localparam logic [2:0] StIgnored  = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StAdded    = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StReadOk   = 3'd4;
  localparam logic [2:0] StReadMiss = 3'd5;
  localparam logic [2:0] StCleared  = 3'd6;

  localparam logic [2:0] FrameTypeMask = 3'h7;
  localparam logic [1:0] AddrModeMask  = 2'h3;
  localparam logic [15:0] ShortNone    = 16'hFFFF;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch inputs of accepted transaction
    logic step;     // in-order command handling (byte/read/clear/other)
    logic search;   // compare one table entry
    logic fetch;    // read table at selected index
    logic commit;   // write table / emit result
  } wfst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_search; // completed frame with usable source
    logic need_fetch;  // read command in range
    logic search_done; // match found or end of table
  } wfst_sts_t;

endpackage

`default_nettype wire

FILE: rtl/wfst_ctrl.sv
// ----------------------------------------------------------------------------
// wfst_ctrl: sequencing state machine
// Steps each transaction through capture and decode and, where needed, table search, fetch, wait and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module wfst_ctrl
  import wfst_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wfst_sts_t      sts_i,
  output wfst_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SEARCH = 6'b000100,
    S_FETCH  = 6'b001000,
    S_WAIT   = 6'b010000,
    S_COMMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.step = 1'b1;
        if (sts_i.need_search) state_d = S_SEARCH;
        else if (sts_i.need_fetch) state_d = S_FETCH;
        else state_d = S_IDLE;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.search_done) state_d = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: state_d = S_COMMIT;
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

`default_nettype wire

FILE: rtl/wfst_dpath.sv
// ----------------------------------------------------------------------------
// wfst_dpath: header capture, decode and device table
// Holds the header bytes, the device table memories and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wfst_dpath
  import wfst_pkg::*;
#(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wfst_cmd_t        cmd_i,
  output wfst_sts_t        sts_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_start_i,
  input  wire logic [4:0]  radio_channel_i,
  input  wire logic signed [7:0] rssi_in_i,
  input  wire logic [7:0]  lqi_in_i,
  input  wire logic [31:0] tick_now_i,
  input  wire logic [4:0]  read_index_i,
  output logic             strobe_o,
  output logic [2:0]       status_o,
  output logic [4:0]       entry_index_o,
  output logic [15:0]      pan_id_o,
  output logic [15:0]      short_address_o,
  output logic [63:0]      extended_address_o,
  output logic [4:0]       entry_channel_o,
  output logic signed [7:0] entry_rssi_o,
  output logic [7:0]       entry_lqi_o,
  output logic [31:0]      seen_tick_o,
  output logic [31:0]      frames_seen_o,
  output logic [5:0]       device_total_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned HdrW = $clog2(HdrDepth);

  // captured transaction
  logic [1:0]  func_q;
  logic [7:0]  byte_q;
  logic        fs_q;
  logic [4:0]  chan_q;
  logic [7:0]  rssi_q, lqi_q;
  logic [31:0] tick_q;
  logic [4:0]  ridx_q;

  logic [7:0]  bpos_q, flen_q;
  logic [15:0] fctl_q;
  logic [7:0]  hdr_q [HdrDepth];
  logic [CntW-1:0] count_q;

  // parsed key
  logic [15:0] pan_q, shrt_q;
  logic [63:0] ext_q;
  logic        do_frame_q;   // frame lookup pending
  logic        found_q;
  logic [CntW-1:0] sidx_q;   // search / target index

  // entry under compare (registered table read)
  logic [15:0] kpan_q, kshort_q;
  logic [CntW-1:0] kidx_q;
  logic        kval_q;       // entry lies below the count
  logic        kprim_q;      // first read issued
  logic        hit;

  // table
  logic [15:0] t_pan   [TableDepth];
  logic [15:0] t_short [TableDepth];
  logic [63:0] t_ext   [TableDepth];
  logic [4:0]  t_chan  [TableDepth];
  logic [7:0]  t_rssi  [TableDepth];
  logic [7:0]  t_lqi   [TableDepth];
  logic [31:0] t_last  [TableDepth];
  logic [31:0] t_frm   [TableDepth];

  logic [15:0] rd_pan, rd_short;
  logic [63:0] rd_ext;
  logic [4:0]  rd_chan;
  logic [7:0]  rd_rssi, rd_lqi;
  logic [31:0] rd_last, rd_frm;

  function automatic logic [7:0] hb(input logic [7:0] hdr [HdrDepth], input int unsigned i);
    return (i < HdrDepth) ? hdr[i[HdrW-1:0]] : 8'h00;
  endfunction

  // frame decode on the header with the completing byte merged in
  logic [7:0]  hv [HdrDepth];
  logic        completes;
  logic        usable;
  logic [15:0] pan_c, shrt_c, fc_c;
  logic [63:0] ext_c;
  logic [4:0]  off_a, off_b;
  logic [2:0]  ftype;
  logic [1:0]  smode, dmode;

  always_comb begin
    for (int unsigned j = 0; j < HdrDepth; j++) begin
      hv[j] = hdr_q[j];
      if (bpos_q == 8'(j)) hv[j] = byte_q;
    end
    completes = (func_q == FuncByte) && !fs_q && (bpos_q != 8'd0) && (bpos_q >= flen_q);
    fc_c  = {hv[2], hv[1]};
    ftype = fc_c[2:0] & FrameTypeMask;
    smode = fc_c[15:14] & AddrModeMask;
    dmode = fc_c[11:10] & AddrModeMask;
    off_a = 5'd5;
    if (dmode == 2'd2) off_a = 5'd7;
    else if (dmode == 2'd3) off_a = 5'd13;
    if (!fc_c[6] && ({3'd0, off_a} + 8'd2 <= flen_q)) begin
      pan_c = {hb(hv, off_a + 2), hb(hv, off_a + 1)};
      off_b = off_a + 5'd2;
    end else begin
      pan_c = {hv[5], hv[4]};
      off_b = off_a;
    end
    shrt_c = ShortNone;
    ext_c  = '0;
    usable = (ftype == 3'd0 || ftype == 3'd1) && (flen_q >= 8'd7) && (smode != 2'd0);
    if (smode == 2'd2 && ({3'd0, off_b} + 8'd2 <= flen_q)) begin
      shrt_c = {hb(hv, off_b + 2), hb(hv, off_b + 1)};
    end else if (smode == 2'd3 && ({3'd0, off_b} + 8'd8 <= flen_q)) begin
      for (int unsigned k = 0; k < 8; k++) ext_c[8*k +: 8] = hb(hv, off_b + 1 + k);
    end else begin
      usable = 1'b0;
    end
  end

  logic rd_ok;
  assign rd_ok = ({{(CntW > 5 ? CntW - 5 : 0){1'b0}}, ridx_q} < count_q) &&
                 (32'(ridx_q) < TableDepth);

  // search ends on a key match, or on the first slot at or past the count
  assign hit = kval_q && (kpan_q == pan_q) && (kshort_q == shrt_q);

  assign sts_o.need_search = completes && usable;
  assign sts_o.need_fetch  = (func_q == FuncRead) && rd_ok;
  assign sts_o.search_done = hit || (kprim_q && !kval_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i; byte_q <= data_byte_i; fs_q <= frame_start_i;
      chan_q <= radio_channel_i; rssi_q <= rssi_in_i; lqi_q <= lqi_in_i;
      tick_q <= tick_now_i; ridx_q <= read_index_i;
    end
    if (cmd_i.step) begin
      pan_q <= pan_c; shrt_q <= shrt_c; ext_q <= ext_c;
      sidx_q <= (func_q == FuncRead) ? CntW'(ridx_q) : '0;
      kval_q <= 1'b0; kprim_q <= 1'b0;
    end
    if (cmd_i.search) begin
      kpan_q   <= t_pan[sidx_q[IdxW-1:0]];
      kshort_q <= t_short[sidx_q[IdxW-1:0]];
      kidx_q   <= sidx_q;
      kval_q   <= (sidx_q < count_q);
      kprim_q  <= 1'b1;
      // on the last cycle the target is the slot just compared
      sidx_q   <= sts_o.search_done ? kidx_q : sidx_q + 1'b1;
    end
    if (cmd_i.fetch) begin
      rd_pan  <= t_pan[sidx_q[IdxW-1:0]];  rd_short <= t_short[sidx_q[IdxW-1:0]];
      rd_ext  <= t_ext[sidx_q[IdxW-1:0]];  rd_chan  <= t_chan[sidx_q[IdxW-1:0]];
      rd_rssi <= t_rssi[sidx_q[IdxW-1:0]]; rd_lqi   <= t_lqi[sidx_q[IdxW-1:0]];
      rd_last <= t_last[sidx_q[IdxW-1:0]]; rd_frm   <= t_frm[sidx_q[IdxW-1:0]];
      found_q <= (sidx_q < count_q);
    end
    if (cmd_i.commit && do_frame_q && (found_q || (count_q < CntW'(TableDepth)))) begin
      if (!found_q) begin
        t_pan[sidx_q[IdxW-1:0]]  <= pan_q;
        t_short[sidx_q[IdxW-1:0]] <= shrt_q;
        t_ext[sidx_q[IdxW-1:0]]  <= ext_q;
        t_chan[sidx_q[IdxW-1:0]] <= chan_q;
      end
      t_rssi[sidx_q[IdxW-1:0]] <= rssi_q;
      t_lqi[sidx_q[IdxW-1:0]]  <= lqi_q;
      t_last[sidx_q[IdxW-1:0]] <= tick_q;
      t_frm[sidx_q[IdxW-1:0]]  <= found_q ? rd_frm + 32'd1 : 32'd1;
    end
  end

  // control registers and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q <= '0; flen_q <= '0; fctl_q <= '0; count_q <= '0;
      do_frame_q <= 1'b0; strobe_o <= 1'b0;
      for (int unsigned j = 0; j < HdrDepth; j++) hdr_q[j] <= '0;
      status_o <= '0; entry_index_o <= '0; pan_id_o <= '0; short_address_o <= '0;
      extended_address_o <= '0; entry_channel_o <= '0; entry_rssi_o <= '0;
      entry_lqi_o <= '0; seen_tick_o <= '0; frames_seen_o <= '0; device_total_o <= '0;
    end else begin
      strobe_o <= 1'b0;
      if (cmd_i.step) begin
        do_frame_q <= 1'b0;
        status_o <= StIgnored; entry_index_o <= '0; pan_id_o <= '0;
        short_address_o <= '0; extended_address_o <= '0; entry_channel_o <= '0;
        entry_rssi_o <= '0; entry_lqi_o <= '0; seen_tick_o <= '0; frames_seen_o <= '0;
        device_total_o <= 6'(count_q);
        unique case (func_q)
          FuncRead: begin
            if (!rd_ok) begin
              strobe_o <= 1'b1; status_o <= StReadMiss; entry_index_o <= ridx_q;
            end
          end
          FuncClear: begin
            count_q <= '0; strobe_o <= 1'b1; status_o <= StCleared; device_total_o <= '0;
          end
          FuncNone: strobe_o <= 1'b1;
          FuncByte: begin
            if (fs_q) begin
              for (int unsigned j = 1; j < HdrDepth; j++) hdr_q[j] <= '0;
              hdr_q[0] <= byte_q; flen_q <= byte_q;
              if (byte_q < 8'd3) begin
                bpos_q <= '0; strobe_o <= 1'b1;
              end else bpos_q <= 8'd1;
            end else if (bpos_q != 8'd0) begin
              if (bpos_q < 8'(HdrDepth)) hdr_q[bpos_q[HdrW-1:0]] <= byte_q;
              if (completes) begin
                bpos_q <= '0; fctl_q <= fc_c;
                if (usable) do_frame_q <= 1'b1;
                else strobe_o <= 1'b1;
              end else bpos_q <= bpos_q + 8'd1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        strobe_o <= 1'b1;
        if (!do_frame_q) begin
          status_o <= StReadOk; entry_index_o <= 5'(sidx_q);
          pan_id_o <= rd_pan; short_address_o <= rd_short; extended_address_o <= rd_ext;
          entry_channel_o <= rd_chan; entry_rssi_o <= rd_rssi; entry_lqi_o <= rd_lqi;
          seen_tick_o <= rd_last; frames_seen_o <= rd_frm;
        end else if (!found_q && (count_q >= CntW'(TableDepth))) begin
          status_o <= StFull; pan_id_o <= pan_q; short_address_o <= shrt_q;
          extended_address_o <= ext_q; entry_channel_o <= chan_q;
          entry_rssi_o <= rssi_q; entry_lqi_o <= lqi_q; seen_tick_o <= tick_q;
        end else begin
          status_o <= found_q ? StUpdated : StAdded;
          entry_index_o <= 5'(sidx_q);
          pan_id_o <= found_q ? rd_pan : pan_q;
          short_address_o <= found_q ? rd_short : shrt_q;
          extended_address_o <= found_q ? rd_ext : ext_q;
          entry_channel_o <= found_q ? rd_chan : chan_q;
          entry_rssi_o <= rssi_q; entry_lqi_o <= lqi_q; seen_tick_o <= tick_q;
          frames_seen_o <= found_q ? rd_frm + 32'd1 : 32'd1;
          if (!found_q) begin
            count_q <= count_q + 1'b1;
            device_total_o <= 6'(count_q + 1'b1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wpan_frame_source_tracker.sv
// ----------------------------------------------------------------------------
// wpan_frame_source_tracker: 802.15.4 MAC header source tracker
// Parses received frames byte by byte and keeps a table of source devices.
// ----------------------------------------------------------------------------
// Usage:
//  - One transaction is accepted on a clock edge with start high and busy low.
//    func selects a frame byte, a table read, a table clear, or nothing.
//  - A frame begins with its length byte (frame_start high); the byte at that
//    position completes the frame and triggers header decode and lookup.
//  - A result shows on the result ports for one cycle with strobe high; the
//    receiver cannot stall, so the result must be taken that cycle.
//  - Each transaction is captured and decoded; a byte that completes nothing,
//    and any transaction that gives an immediate result, ends there. A table
//    read in range goes on through fetch, wait and commit. A completed frame
//    with a usable source first searches the table serially, up to a key match
//    or the end of the entries, and then goes through fetch, wait and commit.
//  - Reset clears the frame parser and the entry count; table contents are
//    left as they were and are only read below the entry count.
//  - The table is a set of memories with registered reads, searched one
//    entry per cycle, each entry compared in the cycle after its read.
// ----------------------------------------------------------------------------
`default_nettype none

module wpan_frame_source_tracker
  import wfst_pkg::*;
#(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_start_i,
  input  wire logic [4:0]  radio_channel_i,
  input  wire logic signed [7:0] rssi_in_i,
  input  wire logic [7:0]  lqi_in_i,
  input  wire logic [31:0] tick_now_i,
  input  wire logic [4:0]  read_index_i,
  output logic             strobe,
  output logic [2:0]       status_o,
  output logic [4:0]       entry_index_o,
  output logic [15:0]      pan_id_o,
  output logic [15:0]      short_address_o,
  output logic [63:0]      extended_address_o,
  output logic [4:0]       entry_channel_o,
  output logic signed [7:0] entry_rssi_o,
  output logic [7:0]       entry_lqi_o,
  output logic [31:0]      seen_tick_o,
  output logic [31:0]      frames_seen_o,
  output logic [5:0]       device_total_o
);

  wfst_cmd_t cmd;
  wfst_sts_t sts;

  wfst_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .cmd_o(cmd)
  );

  wfst_dpath #(.TableDepth(TableDepth)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .func_i, .data_byte_i, .frame_start_i, .radio_channel_i, .rssi_in_i,
    .lqi_in_i, .tick_now_i, .read_index_i,
    .strobe_o(strobe), .status_o, .entry_index_o, .pan_id_o, .short_address_o,
    .extended_address_o, .entry_channel_o, .entry_rssi_o, .entry_lqi_o,
    .seen_tick_o, .frames_seen_o, .device_total_o
  );

endmodule

`default_nettype wire

FILE: sim/wpan_frame_source_tracker_tb.sv
// ----------------------------------------------------------------------------
// wpan_frame_source_tracker_tb: self-checking bench for the frame source tracker
// Drives frame bytes, table reads, clears and no-op commands with random gaps, predicts every
// result with an independent model of the parser and device table, and checks
// each strobed result field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module wpan_frame_source_tracker_tb;
  import wfst_pkg::*;

  localparam int Depth = 32;
  localparam int HdrLen = 24;
  localparam longint CycleLimit = 400000;
  localparam int ItemBudget = 600;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  index;
    logic [15:0] pan;
    logic [15:0] src_short;
    logic [63:0] src_ext;
    logic [4:0]  channel;
    logic [7:0]  rssi;
    logic [7:0]  lqi;
    logic [31:0] seen;
    logic [31:0] frames;
    logic [5:0]  total;
  } tracker_result_t;

  // Scoreboard: owns the predicted device table and the queue of pending results.
  class device_table_sb;
    logic [7:0]  pos, flen;
    logic [7:0]  hdr [HdrLen];
    logic [15:0] t_pan [Depth];
    logic [15:0] t_short [Depth];
    logic [63:0] t_ext [Depth];
    logic [4:0]  t_chan [Depth];
    logic [7:0]  t_rssi [Depth];
    logic [7:0]  t_lqi [Depth];
    logic [31:0] t_seen [Depth];
    logic [31:0] t_frames [Depth];
    int          count;
    int          errors;
    tracker_result_t pending_q[$];

    function new();
      pos = '0; flen = '0; count = 0; errors = 0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function logic [7:0] hbyte(int i);
      return (i < HdrLen) ? hdr[i] : 8'h00;
    endfunction

    function tracker_result_t blank(logic [2:0] st);
      tracker_result_t r;
      r = '0;
      r.status = st;
      r.total = count[5:0];
      return r;
    endfunction

    function tracker_result_t entry(logic [2:0] st, int i);
      tracker_result_t r;
      r = blank(st);
      r.index = i[4:0]; r.pan = t_pan[i]; r.src_short = t_short[i];
      r.src_ext = t_ext[i]; r.channel = t_chan[i]; r.rssi = t_rssi[i];
      r.lqi = t_lqi[i]; r.seen = t_seen[i]; r.frames = t_frames[i];
      return r;
    endfunction

    // decode the completed header and update the device table
    function tracker_result_t close_frame(logic [4:0] ch, logic [7:0] rs, logic [7:0] lq,
                                          logic [31:0] tk);
      logic [15:0] fc, pan, shrt;
      logic [63:0] ext;
      logic [1:0] smode, dmode;
      int off, i;
      bit found;
      tracker_result_t r;
      fc = {hbyte(2), hbyte(1)};
      smode = fc[15:14]; dmode = fc[11:10];
      off = 5; shrt = ShortNone; ext = '0; found = 0;
      r = blank(StIgnored);
      if ((fc[2:0] != 3'd0 && fc[2:0] != 3'd1) || flen < 7 || smode == 2'd0) return r;
      if (dmode == 2'd2) off += 2;
      else if (dmode == 2'd3) off += 8;
      if (!fc[6] && off + 2 <= flen) begin
        pan = {hbyte(off + 2), hbyte(off + 1)};
        off += 2;
      end else begin
        pan = {hbyte(5), hbyte(4)};
      end
      if (smode == 2'd2 && off + 2 <= flen) begin
        shrt = {hbyte(off + 2), hbyte(off + 1)};
      end else if (smode == 2'd3 && off + 8 <= flen) begin
        for (int k = 0; k < 8; k++) ext[8*k +: 8] = hbyte(off + 1 + k);
      end else begin
        return r;
      end
      for (i = 0; i < count; i++)
        if (t_pan[i] == pan && t_short[i] == shrt) begin
          found = 1;
          break;
        end
      if (!found) begin
        if (count >= Depth) begin
          r = blank(StFull);
          r.pan = pan; r.src_short = shrt; r.src_ext = ext;
          r.channel = ch; r.rssi = rs; r.lqi = lq; r.seen = tk;
          return r;
        end
        i = count++;
        t_pan[i] = pan; t_short[i] = shrt; t_ext[i] = ext; t_chan[i] = ch;
        t_frames[i] = 32'd0;
      end
      t_rssi[i] = rs; t_lqi[i] = lq; t_seen[i] = tk;
      t_frames[i] = t_frames[i] + 32'd1;
      return entry(found ? StUpdated : StAdded, i);
    endfunction

    // note one accepted transaction and queue what it should produce
    function void note_input(logic [1:0] fn, logic [7:0] b, logic fs, logic [4:0] ch,
                             logic [7:0] rs, logic [7:0] lq, logic [31:0] tk,
                             logic [4:0] ridx);
      tracker_result_t r;
      if (fn == FuncRead) begin
        if (ridx < count) pending_q.push_back(entry(StReadOk, ridx));
        else begin
          r = blank(StReadMiss);
          r.index = ridx;
          pending_q.push_back(r);
        end
      end else if (fn == FuncClear) begin
        count = 0;
        pending_q.push_back(blank(StCleared));
      end else if (fn == FuncNone) begin
        pending_q.push_back(blank(StIgnored));
      end else if (fs) begin
        foreach (hdr[i]) hdr[i] = '0;
        hdr[0] = b; flen = b;
        if (b < 3) begin
          pos = '0;
          pending_q.push_back(blank(StIgnored));
        end else pos = 8'd1;
      end else if (pos != 0) begin
        if (pos < HdrLen) hdr[pos] = b;
        if (pos >= flen) begin
          pos = '0;
          pending_q.push_back(close_frame(ch, rs, lq, tk));
        end else pos = pos + 8'd1;
      end
    endfunction

    function void check_result(tracker_result_t got);
      tracker_result_t exp;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: status %0d", got.status);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status != exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status); errors++; end
      if (got.index != exp.index) begin
        $error("entry_index: expected %0d, got %0d", exp.index, got.index); errors++; end
      if (got.pan != exp.pan) begin
        $error("pan_id: expected %h, got %h", exp.pan, got.pan); errors++; end
      if (got.src_short != exp.src_short) begin
        $error("short_address: expected %h, got %h", exp.src_short, got.src_short);
        errors++;
      end
      if (got.src_ext != exp.src_ext) begin
        $error("extended_address: expected %h, got %h", exp.src_ext, got.src_ext);
        errors++;
      end
      if (got.channel != exp.channel) begin
        $error("entry_channel: expected %0d, got %0d", exp.channel, got.channel); errors++; end
      if (got.rssi != exp.rssi) begin
        $error("entry_rssi: expected %h, got %h", exp.rssi, got.rssi); errors++; end
      if (got.lqi != exp.lqi) begin
        $error("entry_lqi: expected %h, got %h", exp.lqi, got.lqi); errors++; end
      if (got.seen != exp.seen) begin
        $error("seen_tick: expected %h, got %h", exp.seen, got.seen); errors++; end
      if (got.frames != exp.frames) begin
        $error("frames_seen: expected %0d, got %0d", exp.frames, got.frames); errors++; end
      if (got.total != exp.total) begin
        $error("device_total: expected %0d, got %0d", exp.total, got.total); errors++; end
    endfunction
  endclass

  logic clk, rst_n, start, busy, strobe;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [4:0]  radio_channel;
  logic signed [7:0] rssi_in;
  logic [7:0]  lqi_in;
  logic [31:0] tick_now;
  logic [4:0]  read_index;
  tracker_result_t res;

  device_table_sb sb;
  longint cycles;
  int     sent_count;      // transactions accepted so far
  bit     quiet_stretch;   // when set, the sender skips its random gaps
  // small pools of PANs and addresses so frames hit existing entries often
  logic [15:0] pan_pool [4];
  logic [15:0] addr_pool [6];

  wpan_frame_source_tracker uut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .func_i(func), .data_byte_i(data_byte), .frame_start_i(frame_start),
    .radio_channel_i(radio_channel), .rssi_in_i(rssi_in), .lqi_in_i(lqi_in),
    .tick_now_i(tick_now), .read_index_i(read_index), .strobe(strobe),
    .status_o(res.status), .entry_index_o(res.index), .pan_id_o(res.pan),
    .short_address_o(res.src_short), .extended_address_o(res.src_ext),
    .entry_channel_o(res.channel), .entry_rssi_o(res.rssi), .entry_lqi_o(res.lqi),
    .seen_tick_o(res.seen), .frames_seen_o(res.frames), .device_total_o(res.total)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result monitor and run-time watchdog, both on the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && strobe) sb.check_result(res);
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one transaction: present at a falling edge, hold until accepted, then drop
  // start at the next falling edge
  task automatic send(logic [1:0] fn, logic [7:0] b, logic fs, logic [4:0] ridx);
    @(negedge clk);
    if (!quiet_stretch)
      while ($urandom_range(0, 99) < 15) @(negedge clk);
    func <= fn; data_byte <= b; frame_start <= fs; read_index <= ridx;
    radio_channel <= 5'($urandom_range(11, 26));
    rssi_in <= 8'($urandom); lqi_in <= 8'($urandom); tick_now <= $urandom;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_input(func, data_byte, frame_start, radio_channel, rssi_in, lqi_in,
                  tick_now, read_index);
    sent_count++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic send_bytes(logic [7:0] bytes[$]);
    send(FuncByte, bytes[0], 1'b1, 5'd0);
    for (int i = 1; i < bytes.size(); i++) send(FuncByte, bytes[i], 1'b0, 5'd0);
  endtask

  // build a beacon/data header with random modes and payload (full_rand also randomizes type and source mode)
  task automatic send_frame(bit full_rand);
    logic [7:0] f[$];
    logic [15:0] fc;
    logic [15:0] dpan, span, sa;
    int extra;
    fc = 16'($urandom);
    if (!full_rand) begin
      fc[2:0] = 3'($urandom_range(0, 1));
      fc[15:14] = 2'($urandom_range(2, 3));
    end
    dpan = pan_pool[$urandom_range(0, 3)];
    span = pan_pool[$urandom_range(0, 3)];
    sa = addr_pool[$urandom_range(0, 5)];
    f.push_back(8'h00);
    f.push_back(fc[7:0]); f.push_back(fc[15:8]); f.push_back(8'($urandom));
    f.push_back(dpan[7:0]); f.push_back(dpan[15:8]);
    if (fc[11:10] == 2'd2) begin f.push_back(8'($urandom)); f.push_back(8'($urandom)); end
    else if (fc[11:10] == 2'd3) for (int k = 0; k < 8; k++) f.push_back(8'($urandom));
    if (!fc[6]) begin f.push_back(span[7:0]); f.push_back(span[15:8]); end
    if (fc[15:14] == 2'd3) for (int k = 0; k < 8; k++) f.push_back(k == 0 ? sa[7:0] : 8'h5A);
    else begin f.push_back(sa[7:0]); f.push_back(sa[15:8]); end
    extra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
    for (int k = 0; k < extra; k++) f.push_back(8'($urandom));
    // sometimes truncate the frame to hit the short/missing-field paths
    if (full_rand || $urandom_range(0, 9) == 0)
      while (f.size() > 3 && $urandom_range(0, 1)) void'(f.pop_back());
    f[0] = 8'(f.size() - 1);
    send_bytes(f);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (5 + Depth + 4) @(negedge clk);
  endtask

  initial begin
    logic [7:0] f[$];
    int pick;
    sb = new();
    cycles = 0; sent_count = 0; quiet_stretch = 0;
    start = 0; func = FuncByte; data_byte = 0; frame_start = 0;
    radio_channel = 11; rssi_in = 0; lqi_in = 0; tick_now = 0; read_index = 0;
    pan_pool = '{16'h0000, 16'hFFFF, 16'h1234, 16'hABCD};
    addr_pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFE, 16'h5555};
    rst_n = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    // directed: reads on empty table, short lengths, no-op func, stray byte
    send(FuncRead, 8'h00, 1'b0, 5'd0);
    send(FuncRead, 8'h00, 1'b0, 5'd31);
    send(FuncByte, 8'h00, 1'b1, 5'd0);
    send(FuncByte, 8'h02, 1'b1, 5'd0);
    send(FuncByte, 8'hFF, 1'b0, 5'd0);
    send(FuncNone, 8'h00, 1'b0, 5'd0);
    // data frame, short source, PAN compressed
    f = '{8'd9, 8'h41, 8'h88, 8'h01, 8'h34, 8'h12, 8'hFF, 8'hFF, 8'h01, 8'h00};
    send_bytes(f);
    send_bytes(f);                       // same source: update
    // beacon, extended source, no dest address
    f = '{8'd15, 8'h00, 8'hC0, 8'h02, 8'hFF, 8'hFF, 8'hCD, 8'hAB,
          8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
    send_bytes(f);
    // ack frame: ignored
    f = '{8'd5, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(f);
    // new start abandons open frame; read and clear in the middle of a frame
    send(FuncByte, 8'd20, 1'b1, 5'd0);
    send(FuncByte, 8'h41, 1'b0, 5'd0);
    f = '{8'd9, 8'h41, 8'h88, 8'h01, 8'h34, 8'h12, 8'hFF, 8'hFF, 8'h02, 8'h00};
    send(FuncByte, f[0], 1'b1, 5'd0);
    send(FuncByte, f[1], 1'b0, 5'd0);
    send(FuncRead, 8'h00, 1'b0, 5'd1);
    send(FuncClear, 8'h00, 1'b0, 5'd0);
    for (int i = 2; i < f.size(); i++) send(FuncByte, f[i], 1'b0, 5'd0);
    send(FuncRead, 8'h00, 1'b0, 5'd0);

    // fill the table past capacity to reach the full case (minimal data frames)
    for (int i = 0; i < Depth + 3; i++) begin
      f = '{8'd7, 8'h41, 8'h80, 8'h00, 8'h00, 8'h77, 8'(i), 8'(i >> 4)};
      send_bytes(f);
    end
    send(FuncRead, 8'h00, 1'b0, 5'd31);
    // long frame with bytes beyond the stored header
    f = '{8'd40};
    for (int i = 0; i < 40; i++) f.push_back(8'($urandom));
    send_bytes(f);
    send(FuncClear, 8'h00, 1'b0, 5'd0);
    // rare all-ones length to cover every data bit
    send(FuncByte, 8'hFF, 1'b1, 5'd0);
    send(FuncClear, 8'h00, 1'b0, 5'd0);

    // random part, up to the transaction budget
    while (sent_count < ItemBudget) begin
      quiet_stretch = (sent_count >= 420 && sent_count < 500);
      pick = $urandom_range(0, 99);
      if (pick < 70) send_frame(1'b0);
      else if (pick < 78) send_frame(1'b1);
      else if (pick < 88) send(FuncRead, 8'($urandom), 1'b0, 5'($urandom));
      else if (pick < 91) send(FuncClear, 8'($urandom), 1'b0, 5'($urandom));
      else if (pick < 94) send(FuncNone, 8'($urandom), 1'($urandom), 5'($urandom));
      else send(FuncByte, 8'($urandom), 1'($urandom), 5'($urandom));
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/wfst_pkg.sv
rtl/wfst_ctrl.sv
rtl/wfst_dpath.sv
rtl/wpan_frame_source_tracker.sv
sim/wpan_frame_source_tracker_tb.sv
